// File: hw/rtl/vtdc_pkg.sv
// Shared types and constants for the visual target drive controller.
// No dependencies; imported by vtdc_wheel, visual_target_drive_controller and tb.
`default_nettype none

package vtdc_pkg;

    typedef logic signed [13:0] drive_t;
    typedef logic [6:0]         speed_t;

    localparam int     DRIVE_MAX       = 8191;
    localparam speed_t MIN_SPEED_MAX   = 7'd100;
    localparam speed_t MIN_SPEED_RESET = 7'd35;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_DRIVE     = 2'd0,
        STATUS_ALIGNED   = 2'd1,
        STATUS_NO_TARGET = 2'd2
    } status_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_TARGET_X        = 3'd0,
        CFG_TARGET_Y        = 3'd1,
        CFG_GAIN_X          = 3'd2,
        CFG_GAIN_Y          = 3'd3,
        CFG_START_MIN_SPEED = 3'd4,
        CFG_PRESENCE_AREA   = 3'd5,
        CFG_SECOND_AREA     = 3'd6
    } cfg_index_t;

    localparam logic [7:0]  TARGET_X_RESET      = 8'd93;
    localparam logic [7:0]  TARGET_Y_RESET      = 8'd71;
    localparam logic [3:0]  GAIN_RESET          = 4'd1;
    localparam logic [14:0] PRESENCE_AREA_RESET = 15'd150;
    localparam logic [14:0] SECOND_AREA_RESET   = 15'd200;

    // Deadband on each error: aligned when ERR_LOW < err < ERR_HIGH
    localparam logic signed [8:0] ERR_LOW  = -9'sd3;
    localparam logic signed [8:0] ERR_HIGH = 9'sd2;

    // Control from the top level to each wheel
    typedef struct packed {
        logic step;   // a driving word is leaving the compute stage
        logic load;   // reload the minimum speed
    } wheel_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/vtdc_wheel.sv
// One wheel: minimum-speed adaptation from stall/motion and raising of small drives.
// Depends on vtdc_pkg.
`default_nettype none

module vtdc_wheel (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire vtdc_pkg::wheel_ctrl_t ctrl,
    input  wire vtdc_pkg::speed_t load_min,
    input  wire vtdc_pkg::drive_t cmd,
    input  wire logic signed [31:0] pos,
    output vtdc_pkg::drive_t     drive
);
    import vtdc_pkg::*;

    speed_t             min_reg, min_next;
    drive_t             prev_cmd_reg;
    logic signed [31:0] prev_pos_reg;

    logic               same_cmd, opp_cmd, moved;
    logic signed [14:0] cmd_w, prev_neg, min_w, min_neg;
    logic signed [8:0]  min_sum;
    logic signed [2:0]  adj;

    always_comb begin
        cmd_w    = {cmd[13], cmd};
        prev_neg = -{prev_cmd_reg[13], prev_cmd_reg};
        same_cmd = (cmd == prev_cmd_reg);
        opp_cmd  = (cmd_w == prev_neg);
        moved    = (pos != prev_pos_reg);

        adj = 3'sd0;
        if (same_cmd && !moved) begin
            adj = adj + 3'sd1;
        end
        if (same_cmd && moved) begin
            adj = adj - 3'sd1;
        end
        if (opp_cmd && moved) begin
            adj = adj - 3'sd2;
        end

        min_sum = $signed({2'b00, min_reg}) + {{6{adj[2]}}, adj};
        if (min_sum < 9'sd0) begin
            min_next = 7'd0;
        end else if (min_sum > $signed({2'b00, MIN_SPEED_MAX})) begin
            min_next = MIN_SPEED_MAX;
        end else begin
            min_next = min_sum[6:0];
        end

        // Raise small nonzero drives to the adapted minimum
        min_w   = {8'd0, min_next};
        min_neg = -min_w;
        drive   = cmd;
        if (cmd_w < 15'sd0 && cmd_w > min_neg) begin
            drive = min_neg[13:0];
        end
        if (cmd_w > 15'sd0 && cmd_w < min_w) begin
            drive = min_w[13:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg      <= MIN_SPEED_RESET;
            prev_cmd_reg <= '0;
            prev_pos_reg <= '0;
        end else if (ctrl.load) begin
            min_reg <= load_min;
        end else if (ctrl.step) begin
            min_reg      <= min_next;
            prev_cmd_reg <= cmd;
            prev_pos_reg <= pos;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/visual_target_drive_controller.sv
// Top level of the visual target drive controller: input register, target
// selection and error/drive arithmetic, result register. Depends on vtdc_pkg, vtdc_wheel.
`default_nettype none

// One frame report in, one drive word out. A report is held in an input
// register; from there the blob choice, deadband test, differential drive
// and per-wheel minimum-speed adaptation are worked out in a single
// combinational pass and the result lands in the output register. m_valid
// rises once the result is registered, which waits while the output register
// holds an untaken word; a new report is taken every cycle
// as long as m_ready keeps the output register draining. The wheel state
// (previous drives, positions, minimum speeds) is updated as each driving word
// leaves the compute stage, so consecutive reports see it at once. No-target
// and aligned words leave that state untouched. Configuration is taken on
// cfg_valid at any time but must only be written while the block is idle;
// writing start_min_speed also reloads both minimum speeds (capped at 100).
module visual_target_drive_controller (
    input  wire                aclk,
    input  wire                aresetn,

    input  wire                cfg_valid,
    output logic               cfg_ready,
    input  wire  [2:0]         cfg_index,
    input  wire  [14:0]        cfg_data,

    input  wire                s_valid,
    output logic               s_ready,
    input  wire  [3:0]         s_blob_count,
    input  wire  [14:0]        s_area_first,
    input  wire  [14:0]        s_area_second,
    input  wire  [7:0]         s_first_x,
    input  wire  [7:0]         s_first_y,
    input  wire  [7:0]         s_second_x,
    input  wire  [7:0]         s_second_y,
    input  wire  signed [31:0] s_left_position,
    input  wire  signed [31:0] s_right_position,

    output logic               m_valid,
    input  wire                m_ready,
    output vtdc_pkg::drive_t   m_left_drive,
    output vtdc_pkg::drive_t   m_right_drive,
    output logic [1:0]         m_status
);
    import vtdc_pkg::*;

    // Configuration registers
    logic [7:0]  target_x_reg, target_y_reg;
    logic [3:0]  gain_x_reg, gain_y_reg;
    logic [14:0] presence_area_reg, second_area_reg;
    speed_t      start_min;

    // Input register
    logic               in_valid_reg;
    logic [3:0]         count_reg;
    logic [14:0]        area1_reg, area2_reg;
    logic [7:0]         x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [31:0] lpos_reg, rpos_reg;

    // Result register
    logic    out_valid_reg;
    drive_t  left_reg, right_reg;
    status_t status_reg;

    logic               advance, present, use_second, aligned;
    logic [7:0]         tx, ty;
    logic signed [8:0]  ex, ey;
    logic signed [14:0] ex_w, ey_w, gx_w, gy_w, ex_g, ey_g;
    logic signed [15:0] dl_sum, dr_sum;
    drive_t             dl, dr, left_out, right_out;
    status_t            status_next;
    wheel_ctrl_t        wheel_ctrl;

    function automatic drive_t sat_drive(input logic signed [15:0] v);
        if (v > 16'(DRIVE_MAX)) begin
            return 14'(DRIVE_MAX);
        end else if (v < -16'(DRIVE_MAX)) begin
            return 14'(-DRIVE_MAX);
        end
        return v[13:0];
    endfunction

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_left_drive  = left_reg;
    assign m_right_drive = right_reg;
    assign m_status      = status_reg;

    // Minimum speed load value, capped
    assign start_min = (cfg_data[6:0] > MIN_SPEED_MAX) ? MIN_SPEED_MAX : cfg_data[6:0];

    always_comb begin
        present    = (area1_reg >= presence_area_reg);
        use_second = (count_reg >= 4'd2) && (area2_reg > second_area_reg)
                     && (x1_reg > x2_reg) && (y1_reg < y2_reg);
        tx = use_second ? x2_reg : x1_reg;
        ty = use_second ? y2_reg : y1_reg;
        ex = $signed({1'b0, target_x_reg}) - $signed({1'b0, tx});
        ey = $signed({1'b0, target_y_reg}) - $signed({1'b0, ty});
        aligned = (ex > ERR_LOW) && (ex < ERR_HIGH) && (ey > ERR_LOW) && (ey < ERR_HIGH);

        ex_w = {{6{ex[8]}}, ex};
        ey_w = {{6{ey[8]}}, ey};
        gx_w = {11'd0, gain_x_reg};
        gy_w = {11'd0, gain_y_reg};
        ex_g = ex_w * gx_w;
        ey_g = ey_w * gy_w;
        dl_sum = {ey_g[14], ey_g} - {ex_g[14], ex_g};
        dr_sum = {ey_g[14], ey_g} + {ex_g[14], ex_g};
        dl = sat_drive(dl_sum);
        dr = sat_drive(dr_sum);

        if (!present) begin
            status_next = STATUS_NO_TARGET;
        end else if (aligned) begin
            status_next = STATUS_ALIGNED;
        end else begin
            status_next = STATUS_DRIVE;
        end

        wheel_ctrl.step = advance && (status_next == STATUS_DRIVE);
        wheel_ctrl.load = cfg_valid && (cfg_index == CFG_START_MIN_SPEED);
    end

    vtdc_wheel u_left (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (wheel_ctrl),
        .load_min (start_min),
        .cmd      (dl),
        .pos      (lpos_reg),
        .drive    (left_out)
    );

    vtdc_wheel u_right (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (wheel_ctrl),
        .load_min (start_min),
        .cmd      (dr),
        .pos      (rpos_reg),
        .drive    (right_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_x_reg      <= TARGET_X_RESET;
            target_y_reg      <= TARGET_Y_RESET;
            gain_x_reg        <= GAIN_RESET;
            gain_y_reg        <= GAIN_RESET;
            presence_area_reg <= PRESENCE_AREA_RESET;
            second_area_reg   <= SECOND_AREA_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_TARGET_X:      target_x_reg      <= cfg_data[7:0];
                CFG_TARGET_Y:      target_y_reg      <= cfg_data[7:0];
                CFG_GAIN_X:        gain_x_reg        <= cfg_data[3:0];
                CFG_GAIN_Y:        gain_y_reg        <= cfg_data[3:0];
                CFG_PRESENCE_AREA: presence_area_reg <= cfg_data;
                CFG_SECOND_AREA:   second_area_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: hold the word until the next stage takes it
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            count_reg <= s_blob_count;
            area1_reg <= s_area_first;
            area2_reg <= s_area_second;
            x1_reg    <= s_first_x;
            y1_reg    <= s_first_y;
            x2_reg    <= s_second_x;
            y2_reg    <= s_second_y;
            lpos_reg  <= s_left_position;
            rpos_reg  <= s_right_position;
        end
        if (advance) begin
            status_reg <= status_next;
            if (status_next == STATUS_DRIVE) begin
                left_reg  <= left_out;
                right_reg <= right_out;
            end else begin
                left_reg  <= '0;
                right_reg <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for visual_target_drive_controller: random frame reports
// with random valid/ready gaps, checked against an in-bench drive predictor.
// Depends on vtdc_pkg and the controller RTL only.
`timescale 1ns / 1ps

module tb;

    import vtdc_pkg::*;

    localparam int         CYCLE_LIMIT = 500000;
    localparam logic [2:0] CFG_NONE    = 3'd7;   // beyond the register file

    typedef struct packed {
        logic [3:0]         blob_count;
        logic [14:0]        area_first;
        logic [14:0]        area_second;
        logic [7:0]         first_x;
        logic [7:0]         first_y;
        logic [7:0]         second_x;
        logic [7:0]         second_y;
        logic signed [31:0] left_position;
        logic signed [31:0] right_position;
    } frame_t;

    typedef struct packed {
        drive_t  left_drive;
        drive_t  right_drive;
        status_t status;
    } drive_word_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [14:0] cfg_data  = '0;
    logic        cfg_ready;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    frame_t      frame_q   = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    drive_t      m_left_drive;
    drive_t      m_right_drive;
    logic [1:0]  m_status;

    // Predictor copy of the registers and the wheel state
    logic [7:0]         aim_x, aim_y;
    logic [3:0]         gain_h, gain_v;
    speed_t             start_speed;
    logic [14:0]        presence_min, second_min;
    int                 last_cmd_l, last_cmd_r, min_l, min_r;
    logic signed [31:0] last_pos_l, last_pos_r;

    frame_t      reports[$];
    drive_word_t drive_words[$];
    frame_t      last_report = '0;
    int          reports_open = 0;
    int          words_seen   = 0;
    int          mismatches   = 0;
    int          cycle_count  = 0;
    int          send_gap = 0, send_calm = 0;
    int          recv_gap = 0, recv_calm = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    visual_target_drive_controller i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_blob_count     (frame_q.blob_count),
        .s_area_first     (frame_q.area_first),
        .s_area_second    (frame_q.area_second),
        .s_first_x        (frame_q.first_x),
        .s_first_y        (frame_q.first_y),
        .s_second_x       (frame_q.second_x),
        .s_second_y       (frame_q.second_y),
        .s_left_position  (frame_q.left_position),
        .s_right_position (frame_q.right_position),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_left_drive     (m_left_drive),
        .m_right_drive    (m_right_drive),
        .m_status         (m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int clamp(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void reset_model();
        aim_x        = TARGET_X_RESET;
        aim_y        = TARGET_Y_RESET;
        gain_h       = GAIN_RESET;
        gain_v       = GAIN_RESET;
        start_speed  = MIN_SPEED_RESET;
        presence_min = PRESENCE_AREA_RESET;
        second_min   = SECOND_AREA_RESET;
        last_cmd_l   = 0;
        last_cmd_r   = 0;
        last_pos_l   = '0;
        last_pos_r   = '0;
        min_l        = MIN_SPEED_RESET;
        min_r        = MIN_SPEED_RESET;
    endfunction

    function automatic void load_reg(logic [2:0] idx, logic [14:0] val);
        case (idx)
            CFG_TARGET_X:      aim_x = val[7:0];
            CFG_TARGET_Y:      aim_y = val[7:0];
            CFG_GAIN_X:        gain_h = val[3:0];
            CFG_GAIN_Y:        gain_v = val[3:0];
            CFG_START_MIN_SPEED: begin
                start_speed = val[6:0];
                min_l = clamp(int'(start_speed), 0, MIN_SPEED_MAX);
                min_r = min_l;
            end
            CFG_PRESENCE_AREA: presence_min = val;
            CFG_SECOND_AREA:   second_min = val;
            default: ;
        endcase
    endfunction

    function automatic int next_min_speed(int m, int cmd, int prev, bit moved);
        if (cmd == prev && !moved) m = m + 1;
        if (cmd == prev && moved) m = m - 1;
        if (cmd == -prev && moved) m = m - 2;
        return clamp(m, 0, MIN_SPEED_MAX);
    endfunction

    function automatic int lift_drive(int d, int m);
        if (d < 0 && d > -m) d = -m;
        if (d > 0 && d < m) d = m;
        return clamp(d, -DRIVE_MAX, DRIVE_MAX);
    endfunction

    // Work out the drive word for one accepted report and, for a driving word, advance the wheel state
    function automatic drive_word_t steer(frame_t f);
        drive_word_t w;
        int tx, ty, ax, ay, gx, gy, ex, ey, dl, dr;
        w.left_drive  = '0;
        w.right_drive = '0;
        w.status      = STATUS_DRIVE;
        if (f.area_first < presence_min) begin
            w.status = STATUS_NO_TARGET;
            return w;
        end
        tx = f.first_x;
        ty = f.first_y;
        if (f.blob_count >= 2 && f.area_second > second_min &&
            f.first_x > f.second_x && f.first_y < f.second_y) begin
            tx = f.second_x;
            ty = f.second_y;
        end
        ax = aim_x;
        ay = aim_y;
        gx = gain_h;
        gy = gain_v;
        ex = ax - tx;
        ey = ay - ty;
        if (ex > -3 && ex < 2 && ey > -3 && ey < 2) begin
            w.status = STATUS_ALIGNED;
            return w;
        end
        dl = clamp(-ex * gx + ey * gy, -DRIVE_MAX, DRIVE_MAX);
        dr = clamp(ex * gx + ey * gy, -DRIVE_MAX, DRIVE_MAX);
        min_l = next_min_speed(min_l, dl, last_cmd_l, f.left_position != last_pos_l);
        min_r = next_min_speed(min_r, dr, last_cmd_r, f.right_position != last_pos_r);
        last_cmd_l = dl;
        last_cmd_r = dr;
        last_pos_l = f.left_position;
        last_pos_r = f.right_position;
        w.left_drive  = 14'(lift_drive(dl, min_l));
        w.right_drive = 14'(lift_drive(dr, min_r));
        return w;
    endfunction

    function automatic frame_t make_report(logic [3:0] count, logic [14:0] a1, logic [14:0] a2,
                                           logic [7:0] x1, logic [7:0] y1,
                                           logic [7:0] x2, logic [7:0] y2,
                                           logic signed [31:0] lp, logic signed [31:0] rp);
        frame_t f;
        f.blob_count     = count;
        f.area_first     = a1;
        f.area_second    = a2;
        f.first_x        = x1;
        f.first_y        = y1;
        f.second_x       = x2;
        f.second_y       = y2;
        f.left_position  = lp;
        f.right_position = rp;
        return f;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [7:0] jitter(logic [7:0] c, int spread);
        int d;
        d = $urandom_range(0, 2 * spread);
        return 8'(clamp(int'(c) + d - spread, 0, 255));
    endfunction

    // Areas around a threshold, with the odd one anywhere in range
    function automatic logic [14:0] around_area(logic [14:0] base);
        int r, d;
        r = $urandom_range(0, 99);
        d = $urandom_range(1, 400);
        if (r < 15) return 15'($urandom);
        if (r < 30 && base != 0) return base - 15'd1;
        if (r < 40) return base;
        return 15'(clamp(int'(base) + d, 0, 32767));
    endfunction

    function automatic logic signed [31:0] next_pos(logic signed [31:0] p);
        int r, d;
        r = $urandom_range(0, 99);
        d = $urandom_range(1, 20);
        if (r < 45) return p;
        if (r < 85) return p + d;
        return $urandom;
    endfunction

    function automatic frame_t random_report(frame_t last);
        frame_t f;
        int r;
        r = $urandom_range(0, 99);
        f = last;
        if (r < 30) begin
            // repeat the last report, or mirror it about the set point to flip the drives
            if (r >= 20) begin
                f.first_x = 8'(clamp(2 * int'(aim_x) - int'(last.first_x), 0, 255));
                f.first_y = 8'(clamp(2 * int'(aim_y) - int'(last.first_y), 0, 255));
            end
        end else begin
            f.blob_count  = 4'($urandom_range(0, 15));
            f.area_first  = around_area(presence_min);
            f.area_second = around_area(second_min);
            f.first_x  = ($urandom_range(0, 99) < 15) ? 8'($urandom) : jitter(aim_x, 6);
            f.first_y  = ($urandom_range(0, 99) < 15) ? 8'($urandom) : jitter(aim_y, 6);
            f.second_x = ($urandom_range(0, 1) == 0) ? 8'($urandom) : jitter(aim_x, 40);
            f.second_y = ($urandom_range(0, 1) == 0) ? 8'($urandom) : jitter(aim_y, 40);
        end
        f.left_position  = next_pos(last.left_position);
        f.right_position = next_pos(last.right_position);
        return f;
    endfunction

    task automatic queue_report(frame_t f);
        reports.push_back(f);
        reports_open++;
    endtask

    task automatic settle();
        while (reports_open != 0 || drive_words.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [14:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        load_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [14:0] tx, logic [14:0] ty, logic [14:0] gx, logic [14:0] gy,
                             logic [14:0] smin, logic [14:0] pres, logic [14:0] sec);
        write_reg(CFG_TARGET_X, tx);
        write_reg(CFG_TARGET_Y, ty);
        write_reg(CFG_GAIN_X, gx);
        write_reg(CFG_GAIN_Y, gy);
        write_reg(CFG_START_MIN_SPEED, smin);
        write_reg(CFG_PRESENCE_AREA, pres);
        write_reg(CFG_SECOND_AREA, sec);
    endtask

    task automatic run_random(int n);
        frame_t f;
        repeat (n) begin
            f = random_report(last_report);
            last_report = f;
            queue_report(f);
        end
        settle();
    endtask

    // Report driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                drive_words.push_back(steer(frame_q));
                reports_open--;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (reports.size() != 0) begin
                    frame_q <= reports.pop_front();
                    s_valid <= 1'b1;
                    if (send_calm > 0) begin
                        send_calm--;
                    end else begin
                        send_gap = idle_len();
                        if ($urandom_range(0, 99) < 3) send_calm = 50;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure, with one long hold-off to fill the block up
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && words_seen >= 80) begin
            hold_done = 1'b1;
            hold_left = 300;
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (recv_calm > 0) begin
                recv_calm--;
            end else if ($urandom_range(0, 3) == 0) begin
                recv_gap = idle_len();
                if ($urandom_range(0, 99) < 5) recv_calm = 50;
            end
        end
    end

    // Drive word monitor
    always @(posedge aclk) begin
        drive_word_t want;
        if (aresetn && m_valid && m_ready) begin
            words_seen++;
            if (drive_words.size() == 0) begin
                $display("%0t: unexpected drive word: left %0d right %0d status %0d",
                         $time, m_left_drive, m_right_drive, m_status);
                mismatches++;
            end else begin
                want = drive_words.pop_front();
                if (m_left_drive !== want.left_drive) begin
                    $display("%0t: left_drive expected %0d, got %0d",
                             $time, want.left_drive, m_left_drive);
                    mismatches++;
                end
                if (m_right_drive !== want.right_drive) begin
                    $display("%0t: right_drive expected %0d, got %0d",
                             $time, want.right_drive, m_right_drive);
                    mismatches++;
                end
                if (m_status !== want.status) begin
                    $display("%0t: status expected %0d, got %0d", $time, want.status, m_status);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        reset_model();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: presence, deadband edges, blob choice and minimum speed updates
        queue_report(make_report(4'd1, 15'd149, 15'd0, 8'd0, 8'd0, 8'd0, 8'd0, 0, 0));
        queue_report(make_report(4'd1, 15'd150, 15'd0, 8'd93, 8'd71, 8'd0, 8'd0, 0, 0));
        queue_report(make_report(4'd1, 15'd200, 15'd0, 8'd95, 8'd71, 8'd0, 8'd0, 0, 0));
        queue_report(make_report(4'd1, 15'd200, 15'd0, 8'd96, 8'd71, 8'd0, 8'd0, 0, 0));
        queue_report(make_report(4'd1, 15'd200, 15'd0, 8'd96, 8'd71, 8'd0, 8'd0, 0, 0));
        queue_report(make_report(4'd1, 15'd200, 15'd0, 8'd96, 8'd71, 8'd0, 8'd0, 5, 5));
        queue_report(make_report(4'd1, 15'd200, 15'd0, 8'd90, 8'd71, 8'd0, 8'd0, 9, 9));
        queue_report(make_report(4'd1, 15'd200, 15'd0, 8'd92, 8'd71, 8'd0, 8'd0, 9, 9));
        queue_report(make_report(4'd1, 15'd200, 15'd0, 8'd91, 8'd71, 8'd0, 8'd0, 9, 9));
        queue_report(make_report(4'd1, 15'd200, 15'd0, 8'd93, 8'd73, 8'd0, 8'd0, 9, 9));
        queue_report(make_report(4'd1, 15'd200, 15'd0, 8'd93, 8'd74, 8'd0, 8'd0, 9, 9));
        queue_report(make_report(4'd1, 15'd200, 15'd0, 8'd93, 8'd70, 8'd0, 8'd0, 9, 9));
        queue_report(make_report(4'd1, 15'd200, 15'd0, 8'd93, 8'd69, 8'd0, 8'd0, 9, 9));
        queue_report(make_report(4'd2, 15'd500, 15'd201, 8'd200, 8'd0, 8'd10, 8'd100, 1, 2));
        queue_report(make_report(4'd1, 15'd500, 15'd201, 8'd200, 8'd0, 8'd10, 8'd100, 1, 2));
        queue_report(make_report(4'd2, 15'd500, 15'd200, 8'd200, 8'd0, 8'd10, 8'd100, 1, 2));
        queue_report(make_report(4'd2, 15'd500, 15'd201, 8'd10, 8'd0, 8'd200, 8'd100, 1, 2));
        queue_report(make_report(4'd2, 15'd500, 15'd201, 8'd200, 8'd100, 8'd10, 8'd0, 1, 2));
        queue_report(make_report(4'd15, 15'h7fff, 15'h7fff, 8'hff, 8'hff, 8'hff, 8'hff,
                                 32'sh7fffffff, 32'sh80000000));
        queue_report(make_report(4'd15, 15'h7fff, 15'h7fff, 8'd0, 8'd0, 8'd0, 8'd0,
                                 32'sh80000000, 32'sh7fffffff));
        queue_report(make_report(4'd0, 15'd0, 15'd0, 8'hff, 8'hff, 8'hff, 8'hff, -1, -1));
        queue_report(make_report(4'd2, 15'h7fff, 15'h7fff, 8'hff, 8'd0, 8'd0, 8'hff, 0, 0));
        settle();
        run_random(100);

        configure('0, '0, '0, '0, '0, '0, '0);
        run_random(80);
        configure('1, '1, '1, '1, '1, '1, '1);
        run_random(80);
        repeat (4) begin
            configure(15'($urandom), 15'($urandom), 15'($urandom), 15'($urandom),
                      15'($urandom),
                      15'($urandom_range(0, 2000)), 15'($urandom_range(0, 2000)));
            write_reg(CFG_NONE, 15'($urandom));
            run_random(75);
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && drive_words.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/vtdc_pkg.sv
hw/rtl/vtdc_wheel.sv
hw/rtl/visual_target_drive_controller.sv
test/tb.sv
